### design/wwsf_pkg.sv
package wwsf_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int TEXT_MAX_DEF    = 65535;

    // Width of the text position, of start_pos and of the result position.
    localparam int POS_W = 16;

    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Items held between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = POS_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHOLE_WORD = 1'b0,
        REG_START_POS  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t kind;
        logic [7:0] data;
        logic       is_space;
        logic       last;
    } item_t;

endpackage

### design/whole_word_substring_finder.sv
// Whole-word substring finder. Load a pattern of 1 to PATTERN_MAX bytes with
// s_tuser = 0 (s_tlast on its final byte), then stream text with s_tuser = 1;
// the text byte carrying s_tlast returns one result transfer holding found and
// the lowest match position at or after start_pos. The block takes one byte
// per clock, pattern or text, while its queue has room: the incoming byte is
// compared against all stored pattern bytes at once, and a two-entry queue
// between the input stage and the matcher plus a registered result let either
// side stall briefly; a waiting result holds the matcher, and a full queue then
// holds the input. When nothing stalls, m_tvalid rises once the last text byte
// has passed through the queue and into the result register. There is no
// clearing pass after reset. Configuration writes are accepted every cycle and
// must only be made while no text run is in progress.
module whole_word_substring_finder
    import wwsf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = TEXT_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] byte_in
    input  logic                  s_tlast,
    input  logic [0:0]            s_tuser,   // [0] func
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [POS_W-1:0]      m_tdata,   // [15:0] position
    output logic [0:0]            m_tuser    // [0] found
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;
    logic  found;

    assign cfg_ready  = 1'b1;
    assign m_tuser[0] = found;

    wwsf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    wwsf_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_found    (found),
        .m_position (m_tdata)
    );

endmodule

### design/wwsf_front.sv
module wwsf_front
    import wwsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic [0:0] s_tuser,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    item_t             classified;
    logic              push;
    logic              pop;

    // Each byte is tagged with its kind and whether it is a space before it is queued.
    always_comb begin
        classified.kind     = item_kind_t'(s_tuser[0]);
        classified.data     = s_tdata;
        classified.is_space = (s_tdata == SPACE_BYTE);
        classified.last     = s_tlast;
    end

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

### design/wwsf_back.sv
module wwsf_back
    import wwsf_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = TEXT_MAX_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  item_t                 in_item,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_found,
    output logic [POS_W-1:0]      m_position
);

    localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
    localparam int WIN_LEN = PATTERN_MAX + 1;
    localparam int CALC_W  = POS_W + 1;
    localparam logic [PATTERN_MAX-1:0] MASK_TOP = PATTERN_MAX'(1) << (PATTERN_MAX - 1);
    localparam logic [WIN_LEN-1:0]     SEL_INIT = WIN_LEN'(1) << PATTERN_MAX;

    // The pattern is a shift line: after L bytes, byte k sits at PATTERN_MAX-L+k.
    logic [7:0]             pat_reg  [PATTERN_MAX];
    logic [7:0]             pat_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] mask_reg, mask_next;
    logic [WIN_LEN-1:0]     sel_reg, sel_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   closed_reg, closed_next;

    logic [7:0]             win_reg   [WIN_LEN];
    logic [7:0]             win_next  [WIN_LEN];
    logic [7:0]             shift_win [WIN_LEN];
    logic [POS_W-1:0]       count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic [POS_W-1:0]       pend_start_reg, pend_start_next;
    logic                   found_reg, found_next;
    logic [POS_W-1:0]       match_pos_reg, match_pos_next;

    logic                   whole_word_reg;
    logic [POS_W-1:0]       start_pos_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;

    logic [PATTERN_MAX-1:0] eq;
    logic [WIN_LEN-1:0]     space_vec;
    logic                   window_hit;
    logic                   before_space;
    logic [CALC_W-1:0]      idx_p1;
    logic [CALC_W-1:0]      len_ext;
    logic [CALC_W-1:0]      start_ext;
    logic                   start_ok;
    logic                   len_ok;
    logic                   below_max;
    logic                   start_zero;
    logic                   take;

    assign in_ready   = !out_valid_reg || m_tready;
    assign take       = in_valid && in_ready;
    assign m_tvalid   = out_valid_reg;
    assign m_found    = out_found_reg;
    assign m_position = out_pos_reg;

    // Window as it stands once the incoming byte has been shifted in, and the
    // parallel compare against the stored pattern.
    always_comb begin
        for (int j = 0; j < WIN_LEN - 1; j++) begin
            shift_win[j] = win_reg[j + 1];
        end
        shift_win[WIN_LEN - 1] = in_item.data;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            eq[j] = !mask_reg[j] || (shift_win[j + 1] == pat_reg[j]);
        end
        for (int j = 0; j < WIN_LEN; j++) begin
            space_vec[j] = (shift_win[j] == SPACE_BYTE);
        end
        window_hit   = &eq;
        before_space = |(sel_reg & space_vec);
        idx_p1       = {1'b0, count_reg} + CALC_W'(1);
        len_ext      = CALC_W'(len_reg);
        start_ext    = idx_p1 - len_ext;
        start_ok     = (start_ext >= {1'b0, start_pos_reg});
        len_ok       = (len_reg != '0) && (idx_p1 >= len_ext);
        below_max    = (count_reg < POS_W'(TEXT_MAX));
        start_zero   = (start_ext == '0);
    end

    always_comb begin
        logic             clear_text;
        logic [LEN_W-1:0] len_base;
        logic [PATTERN_MAX-1:0] mask_base;
        logic [WIN_LEN-1:0] sel_base;

        clear_text      = 1'b0;
        len_base        = len_reg;
        mask_base       = mask_reg;
        sel_base        = sel_reg;
        pat_next        = pat_reg;
        mask_next       = mask_reg;
        sel_next        = sel_reg;
        len_next        = len_reg;
        closed_next     = closed_reg;
        win_next        = win_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_start_next = pend_start_reg;
        found_next      = found_reg;
        match_pos_next  = match_pos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_pos_next    = out_pos_reg;

        if (take) begin
            if (in_item.kind == KIND_PATTERN) begin
                clear_text = 1'b1;
                if (closed_reg) begin
                    len_base    = '0;
                    mask_base   = '0;
                    sel_base    = SEL_INIT;
                    closed_next = 1'b0;
                end
                len_next  = len_base;
                mask_next = mask_base;
                sel_next  = sel_base;
                if (len_base < LEN_W'(PATTERN_MAX)) begin
                    for (int j = 0; j < PATTERN_MAX - 1; j++) begin
                        pat_next[j] = pat_reg[j + 1];
                    end
                    pat_next[PATTERN_MAX - 1] = in_item.data;
                    len_next  = len_base + 1'b1;
                    mask_next = (mask_base >> 1) | MASK_TOP;
                    sel_next  = sel_base >> 1;
                end
                if (in_item.last) begin
                    closed_next = 1'b1;
                end
            end else begin
                win_next = shift_win;
                // A pending candidate is settled before a new one may be taken.
                if (pend_reg) begin
                    if (in_item.is_space && !found_reg) begin
                        found_next     = 1'b1;
                        match_pos_next = pend_start_reg;
                    end
                    pend_next = 1'b0;
                end
                if (!found_next && below_max && len_ok && start_ok && window_hit) begin
                    if (!whole_word_reg) begin
                        found_next     = 1'b1;
                        match_pos_next = start_ext[POS_W-1:0];
                    end else if (start_zero || before_space) begin
                        if (in_item.last) begin
                            found_next     = 1'b1;
                            match_pos_next = start_ext[POS_W-1:0];
                        end else begin
                            pend_next       = 1'b1;
                            pend_start_next = start_ext[POS_W-1:0];
                        end
                    end
                end
                if (below_max) begin
                    count_next = count_reg + 1'b1;
                end
                if (in_item.last) begin
                    out_valid_next = 1'b1;
                    out_found_next = found_next;
                    out_pos_next   = found_next ? match_pos_next : '0;
                    clear_text     = 1'b1;
                end
            end
        end

        if (clear_text) begin
            for (int j = 0; j < WIN_LEN; j++) begin
                win_next[j] = SPACE_BYTE;
            end
            count_next      = '0;
            pend_next       = 1'b0;
            pend_start_next = '0;
            found_next      = 1'b0;
            match_pos_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg       <= '0;
            sel_reg        <= SEL_INIT;
            len_reg        <= '0;
            closed_reg     <= 1'b0;
            for (int j = 0; j < WIN_LEN; j++) begin
                win_reg[j] <= SPACE_BYTE;
            end
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            pend_start_reg <= '0;
            found_reg      <= 1'b0;
            match_pos_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            mask_reg       <= mask_next;
            sel_reg        <= sel_next;
            len_reg        <= len_next;
            closed_reg     <= closed_next;
            win_reg        <= win_next;
            count_reg      <= count_next;
            pend_reg       <= pend_next;
            pend_start_reg <= pend_start_next;
            found_reg      <= found_next;
            match_pos_reg  <= match_pos_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pat_reg       <= pat_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            whole_word_reg <= 1'b0;
            start_pos_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WHOLE_WORD: whole_word_reg <= cfg_data[0];
                REG_START_POS:  start_pos_reg  <= cfg_data[POS_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

### test/testbench.sv
module testbench;
    import wwsf_pkg::*;

    localparam int WIN_LEN       = PATTERN_MAX_DEF + 1;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        item_kind_t kind;
        logic [7:0] data;
        logic       last;
    } feed_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } find_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic [0:0]            s_tuser   = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [POS_W-1:0]      m_tdata;
    logic [0:0]            m_tuser;

    whole_word_substring_finder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Bytes waiting to be driven, and the search results still owed by the block.
    feed_t        feed_queue[$];
    find_result_t expected_finds[$];

    int unsigned queued_items   = 0;
    int unsigned accepted_items = 0;
    int unsigned results_seen   = 0;
    int unsigned matches_seen   = 0;
    int unsigned mismatches     = 0;
    bit          calm           = 1'b0;
    int unsigned feed_gap       = 0;
    int unsigned sink_stall     = 0;

    // Mirror of the finder: pattern, text window, candidate and match state.
    logic [7:0]       pat_mem [PATTERN_MAX_DEF];
    int unsigned      pat_len;
    bit               pat_closed;
    logic [7:0]       window_bytes [WIN_LEN];
    int unsigned      text_pos;
    bit               cand_pending;
    int unsigned      cand_start;
    bit               hit;
    int unsigned      hit_pos;
    bit               cfg_whole;
    logic [POS_W-1:0] cfg_start;

    function automatic void clear_run();
        foreach (window_bytes[i]) window_bytes[i] = SPACE_BYTE;
        text_pos     = 0;
        cand_pending = 1'b0;
        cand_start   = 0;
        hit          = 1'b0;
        hit_pos      = 0;
    endfunction

    function automatic void search_step(input feed_t it);
        int unsigned  idx;
        int unsigned  first;
        bit           same;
        find_result_t res;
        if (it.kind == KIND_PATTERN) begin
            clear_run();
            if (pat_closed) begin
                pat_len    = 0;
                pat_closed = 1'b0;
            end
            if (pat_len < PATTERN_MAX_DEF) begin
                pat_mem[pat_len] = it.data;
                pat_len++;
            end
            if (it.last)
                pat_closed = 1'b1;
            return;
        end
        idx = text_pos;
        for (int k = 0; k < WIN_LEN - 1; k++)
            window_bytes[k] = window_bytes[k + 1];
        window_bytes[WIN_LEN - 1] = it.data;
        // An earlier candidate is settled by this byte before a new one may start.
        if (cand_pending) begin
            if (it.data == SPACE_BYTE && !hit) begin
                hit     = 1'b1;
                hit_pos = cand_start;
            end
            cand_pending = 1'b0;
        end
        if (!hit && idx < TEXT_MAX_DEF && pat_len > 0 && idx + 1 >= pat_len) begin
            first = idx + 1 - pat_len;
            same  = 1'b1;
            for (int k = 0; k < pat_len; k++)
                if (window_bytes[WIN_LEN - pat_len + k] != pat_mem[k])
                    same = 1'b0;
            if (first >= cfg_start && same) begin
                if (!cfg_whole) begin
                    hit     = 1'b1;
                    hit_pos = first;
                end else if (first == 0 || window_bytes[WIN_LEN - 1 - pat_len] == SPACE_BYTE) begin
                    if (it.last) begin
                        hit     = 1'b1;
                        hit_pos = first;
                    end else begin
                        cand_pending = 1'b1;
                        cand_start   = first;
                    end
                end
            end
        end
        if (text_pos < TEXT_MAX_DEF)
            text_pos++;
        if (it.last) begin
            res.found    = hit;
            res.position = hit ? POS_W'(hit_pos) : '0;
            expected_finds.push_back(res);
            clear_run();
        end
    endfunction

    function automatic void note_mismatch(input string what, input find_result_t want,
                                          input find_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("Mismatch, %s: expected found=%0d position=%0d, got found=%0d position=%0d",
                     what, want.found, want.position, got.found, got.position);
    endfunction

    // Driver: one byte in flight at a time, with bursts of idle cycles.
    always @(posedge aclk) begin
        feed_t next_feed;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            feed_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            if (feed_gap != 0) begin
                feed_gap--;
                s_tvalid <= 1'b0;
            end else if (feed_queue.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
                feed_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else if (feed_queue.size() != 0) begin
                next_feed = feed_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= next_feed.kind;
                s_tdata  <= next_feed.data;
                s_tlast  <= next_feed.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: follows register writes and input transfers, checks result transfers.
    always @(posedge aclk) begin
        feed_t        seen;
        find_result_t got;
        find_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_stall = 0;
            pat_len    = 0;
            pat_closed = 1'b0;
            cfg_whole  = 1'b0;
            cfg_start  = '0;
            clear_run();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_WHOLE_WORD: cfg_whole = cfg_data[0];
                    REG_START_POS:  cfg_start = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                seen.kind = item_kind_t'(s_tuser[0]);
                seen.data = s_tdata;
                seen.last = s_tlast;
                search_step(seen);
                accepted_items++;
            end
            if (m_tvalid && m_tready) begin
                got.found    = m_tuser[0];
                got.position = m_tdata;
                results_seen++;
                if (expected_finds.size() == 0) begin
                    note_mismatch("result with nothing expected", '0, got);
                end else begin
                    want = expected_finds.pop_front();
                    if (got.found !== want.found || got.position !== want.position)
                        note_mismatch("search result", want, got);
                    else if (got.found)
                        matches_seen++;
                end
            end
            if (sink_stall != 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("** whole_word_substring_finder: FAILED **");
        $finish;
    end

    function automatic void queue_item(input item_kind_t kind, input logic [7:0] data,
                                       input bit last);
        feed_t it;
        it.kind = kind;
        it.data = data;
        it.last = last;
        feed_queue.push_back(it);
        queued_items++;
    endfunction

    function automatic void queue_string(input item_kind_t kind, input string s,
                                         input bit closed);
        for (int i = 0; i < s.len(); i++)
            queue_item(kind, s[i], closed && i == s.len() - 1);
    endfunction

    // Mostly a small alphabet so that matches are common, with any byte now and then.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: return "a";
            6, 7, 8:          return "b";
            9, 10, 11:        return SPACE_BYTE;
            12:               return "c";
            default:          return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic drain();
        while (accepted_items != queued_items || expected_finds.size() != 0)
            @(posedge aclk);
        // Pattern bytes give no result and may still be inside the block.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(input bit whole, input logic [POS_W-1:0] first_pos);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WHOLE_WORD;
        cfg_data  <= CFG_DATA_W'(whole);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_START_POS;
        cfg_data  <= first_pos;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic void queue_random(input int unsigned budget);
        int unsigned first_item;
        int unsigned n;
        bit          need_pattern;
        bit          open_end;
        bit          cut;
        logic [7:0]  word[$];
        logic [7:0]  line[$];
        first_item   = queued_items;
        need_pattern = 1'b0;
        while (queued_items - first_item < budget || need_pattern) begin
            if (need_pattern || word.size() == 0 || $urandom_range(0, 3) == 0) begin
                word.delete();
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(7, PATTERN_MAX_DEF + 6)
                                                 : $urandom_range(1, 5);
                repeat (n) word.push_back(pick_byte());
                // An unterminated pattern keeps growing when the next pattern arrives.
                open_end = ($urandom_range(0, 9) == 0);
                foreach (word[i])
                    queue_item(KIND_PATTERN, word[i], !open_end && i == word.size() - 1);
                need_pattern = 1'b0;
            end
            line.delete();
            repeat ($urandom_range(0, 12)) line.push_back(pick_byte());
            if ($urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 1)) line.push_back(SPACE_BYTE);
                foreach (word[i]) line.push_back(word[i]);
                if ($urandom_range(0, 1)) line.push_back(SPACE_BYTE);
            end
            repeat ($urandom_range(0, 12)) line.push_back(pick_byte());
            if (line.size() == 0)
                line.push_back(pick_byte());
            // Now and then the text is dropped part way by a new pattern.
            cut = ($urandom_range(0, 11) == 0);
            foreach (line[i])
                queue_item(KIND_TEXT, line[i], !cut && i == line.size() - 1);
            need_pattern = cut;
        end
    endfunction

    initial begin
        bit               whole;
        logic [POS_W-1:0] first_pos;
        int unsigned      budget;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Plain substring mode: empty pattern, pattern restart, abandoned text, byte extremes.
        set_regs(1'b0, '0);
        queue_string(KIND_TEXT, "ab", 1'b1);
        queue_string(KIND_PATTERN, "a", 1'b1);
        queue_string(KIND_PATTERN, "ab", 1'b1);
        queue_string(KIND_TEXT, "xab", 1'b1);
        queue_string(KIND_TEXT, "ab", 1'b0);
        queue_item(KIND_PATTERN, 8'h00, 1'b0);
        queue_item(KIND_PATTERN, 8'hFF, 1'b1);
        queue_item(KIND_TEXT, 8'hFF, 1'b0);
        queue_item(KIND_TEXT, 8'h00, 1'b0);
        queue_item(KIND_TEXT, 8'hFF, 1'b1);
        drain();

        // Whole-word mode: text edges, a rejected first candidate, a pattern that is a space.
        set_regs(1'b1, '0);
        queue_string(KIND_PATTERN, "ab", 1'b1);
        queue_string(KIND_TEXT, "ab", 1'b1);
        queue_string(KIND_TEXT, "xab ab", 1'b1);
        queue_string(KIND_PATTERN, " ", 1'b1);
        queue_string(KIND_TEXT, "   ", 1'b1);
        queue_string(KIND_PATTERN, "a ", 1'b1);
        queue_string(KIND_TEXT, "a a ", 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            budget = 115;
            case (p)
                0: begin whole = 1'b0; first_pos = '0; end
                1: begin whole = 1'b1; first_pos = '0; end
                2: begin whole = 1'b1; first_pos = POS_W'($urandom_range(1, 12)); end
                3: begin whole = 1'b0; first_pos = POS_W'($urandom_range(1, 12)); end
                4: begin whole = 1'b1; first_pos = '1; budget = 40; end
                default: begin
                    whole     = 1'($urandom_range(0, 1));
                    first_pos = POS_W'($urandom_range(0, 3));
                    calm      = 1'b1;
                end
            endcase
            set_regs(whole, first_pos);
            queue_random(budget);
            drain();
        end

        $display("Checked %0d search results (%0d with a match) from %0d input transfers.",
                 results_seen, matches_seen, accepted_items);
        $display("Both match modes, start positions up to the maximum, over-long patterns %s",
                 "and texts cut short by a new pattern were covered.");
        if (mismatches == 0 && expected_finds.size() == 0)
            $display("** whole_word_substring_finder: PASSED **");
        else
            $display("** whole_word_substring_finder: FAILED **");
        $finish;
    end

endmodule
